@@ hdl/sar_pkg.sv @@
`default_nettype none

package sar_pkg;

    // ascii codes recognised by the parser
    localparam logic [7:0] CHAR_R = 8'h52;
    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;

    // readings averaged per window and digits kept per reading
    localparam logic [2:0] READINGS_PER_AVERAGE = 3'd4;
    localparam logic [2:0] MAX_DIGITS           = 3'd4;
    // divide by four is a shift
    localparam int unsigned AVG_SHIFT = 2;

    typedef enum logic [2:0] {
        PHASE_IDLE   = 3'b001,
        PHASE_GOT_R  = 3'b010,
        PHASE_DIGITS = 3'b100
    } sar_phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       window_end;
    } sar_in_t;

    typedef struct packed {
        logic [13:0] average_distance;
        logic [2:0]  readings_found;
    } sar_out_t;

    typedef struct packed {
        sar_phase_t  parse_phase;
        logic [2:0]  digit_count;
        logic [13:0] current_reading;
        logic [2:0]  reading_count;
        logic [15:0] reading_sum;
    } sar_state_t;

    typedef struct packed {
        sar_state_t next_state;
        logic       result_valid;
        sar_out_t   result;
    } sar_step_t;

endpackage

`default_nettype wire

@@ hdl/sonar_ascii_range_averager.sv @@
// Range sensor ASCII averager.
// Input channel (s_valid/s_ready/s_data) takes one received serial byte per
// request, with window_end marking the last byte of a capture window. A
// reading is 'R' followed by up to four digits; the first four readings of a
// window are summed. The result channel (m_valid/m_ready/m_data) gives one
// request per window: the sum divided by four and the number of readings.
// Throughput: one byte per cycle while s_ready is high. Each byte is parsed
// by the combinational parser logic between the state registers and the
// output register. The result of the marked byte is registered in the
// output register, or first in the skid register while the output is held.
// Stall: a result waiting on the output register goes on being held while
// bytes keep flowing; a second result goes to a skid register, and s_ready
// drops only while both hold a result.
// Reset (aresetn low, synchronous): parser state returns to idle with zero
// sum and count, and both result registers are emptied.
`default_nettype none

module sonar_ascii_range_averager (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire sar_pkg::sar_in_t  s_data,
    output logic                   m_valid,
    input  wire                    m_ready,
    output sar_pkg::sar_out_t      m_data
);

    sar_pkg::sar_state_t state_reg;
    sar_pkg::sar_step_t  step;
    logic                out_valid_reg;
    sar_pkg::sar_out_t   out_data_reg;
    logic                skid_valid_reg;
    sar_pkg::sar_out_t   skid_data_reg;
    logic                in_fire;
    logic                out_fire;
    logic                new_result;

    sar_parser u_parser (
        .state   (state_reg),
        .in_data (s_data),
        .step    (step)
    );

    // handshakes
    assign s_ready    = !skid_valid_reg;
    assign in_fire    = s_valid && s_ready;
    assign out_fire   = out_valid_reg && m_ready;
    assign new_result = in_fire && step.result_valid;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_data_reg;

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.parse_phase     <= sar_pkg::PHASE_IDLE;
            state_reg.digit_count     <= 3'd0;
            state_reg.current_reading <= 14'd0;
            state_reg.reading_count   <= 3'd0;
            state_reg.reading_sum     <= 16'd0;
        end else if (in_fire) begin
            state_reg <= step.next_state;
        end
    end

    // output and skid valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || out_fire) begin
                out_valid_reg  <= skid_valid_reg || new_result;
                skid_valid_reg <= skid_valid_reg && new_result;
            end else if (new_result) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // output and skid payload
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_fire) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (new_result) begin
                out_data_reg <= step.result;
            end
        end else if (new_result) begin
            skid_data_reg <= step.result;
        end
    end

`ifndef SYNTHESIS
    // skid holds a result only behind a held output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output empty");

    // a result arriving behind a stalled output goes to the skid
    a_result_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (new_result && out_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("result lost behind stalled output");

    // no more than four readings per window
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.reading_count <= sar_pkg::READINGS_PER_AVERAGE)
        else $error("reading count out of range");

    // the fourth digit always closes the reading
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.digit_count < sar_pkg::MAX_DIGITS)
        else $error("digit count reached the limit with reading open");
`endif

endmodule

`default_nettype wire

@@ hdl/sar_parser.sv @@
`default_nettype none

module sar_parser (
    input  wire sar_pkg::sar_state_t state,
    input  wire sar_pkg::sar_in_t    in_data,
    output sar_pkg::sar_step_t       step
);

    logic               is_digit;
    logic [3:0]         digit_val;
    logic               is_r;
    logic [16:0]        mul_ext;
    logic [13:0]        acc_reading;
    logic [2:0]         acc_count;
    logic [15:0]        open_add;
    logic [15:0]        final_sum;
    sar_pkg::sar_state_t st;

    // byte classification
    always_comb begin
        is_r      = (in_data.rx_byte == sar_pkg::CHAR_R);
        is_digit  = in_data.rx_byte inside {[sar_pkg::CHAR_0:sar_pkg::CHAR_9]};
        digit_val = 4'(in_data.rx_byte - sar_pkg::CHAR_0);
    end

    // multiply-by-ten accumulate of the open reading
    always_comb begin
        mul_ext     = 17'({state.current_reading, 3'b000})
                    + 17'({state.current_reading, 1'b0})
                    + 17'(digit_val);
        acc_reading = mul_ext[13:0];
        acc_count   = state.digit_count + 3'd1;
    end

    // parse one byte
    always_comb begin
        st = state;
        if (is_r) begin
            // close any open reading, then wait for a digit
            if (state.parse_phase == sar_pkg::PHASE_DIGITS) begin
                st.reading_sum = state.reading_sum + 16'(state.current_reading);
            end
            st.parse_phase     = sar_pkg::PHASE_GOT_R;
            st.digit_count     = 3'd0;
            st.current_reading = 14'd0;
        end else if (is_digit && state.parse_phase == sar_pkg::PHASE_GOT_R) begin
            // first digit opens a reading unless the window is full
            if (state.reading_count < sar_pkg::READINGS_PER_AVERAGE) begin
                st.reading_count   = state.reading_count + 3'd1;
                st.parse_phase     = sar_pkg::PHASE_DIGITS;
                st.current_reading = 14'(digit_val);
                st.digit_count     = 3'd1;
            end else begin
                st.parse_phase = sar_pkg::PHASE_IDLE;
            end
        end else if (is_digit && state.parse_phase == sar_pkg::PHASE_DIGITS) begin
            if (acc_count >= sar_pkg::MAX_DIGITS) begin
                // last digit closes the reading at once
                st.reading_sum     = state.reading_sum + 16'(acc_reading);
                st.parse_phase     = sar_pkg::PHASE_IDLE;
                st.digit_count     = 3'd0;
                st.current_reading = 14'd0;
            end else begin
                st.current_reading = acc_reading;
                st.digit_count     = acc_count;
            end
        end else begin
            // any other byte closes the reading
            if (state.parse_phase == sar_pkg::PHASE_DIGITS) begin
                st.reading_sum = state.reading_sum + 16'(state.current_reading);
            end
            st.parse_phase     = sar_pkg::PHASE_IDLE;
            st.digit_count     = 3'd0;
            st.current_reading = 14'd0;
        end
    end

    // window end: close what is open, report and clear
    always_comb begin
        open_add  = (st.parse_phase == sar_pkg::PHASE_DIGITS)
                  ? 16'(st.current_reading) : 16'd0;
        final_sum = st.reading_sum + open_add;

        step.result_valid            = in_data.window_end;
        step.result.average_distance = 14'(final_sum >> sar_pkg::AVG_SHIFT);
        step.result.readings_found   = st.reading_count;

        if (in_data.window_end) begin
            step.next_state.parse_phase     = sar_pkg::PHASE_IDLE;
            step.next_state.digit_count     = 3'd0;
            step.next_state.current_reading = 14'd0;
            step.next_state.reading_count   = 3'd0;
            step.next_state.reading_sum     = 16'd0;
        end else begin
            step.next_state = st;
        end
    end

endmodule

`default_nettype wire
